/* rtl/core/priority_weighted_round_robin_core_macros.svh */
`ifndef PRIORITY_WEIGHTED_ROUND_ROBIN_CORE_MACROS_SVH
`define PRIORITY_WEIGHTED_ROUND_ROBIN_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define PWRR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define PWRR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pwrr_pkg.sv */
package pwrr_pkg;

  localparam int NUM_CELLS = 16;
  localparam int SLOT_W    = $clog2(NUM_CELLS);
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);
  localparam int ID_W      = 4;
  localparam int PRIO_W    = 4;
  localparam int SLICE_W   = 8;
  localparam int TICK_W    = 12;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_IDLE_TICK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // next slot in order, wrapping to zero past the last filled slot
  function automatic logic [SLOT_W-1:0] adv_slot(input logic [SLOT_W-1:0] cur,
                                                 input logic [CNT_W-1:0]  count);
    logic [CNT_W-1:0] n;
    n = CNT_W'(cur) + CNT_W'(1);
    return (n >= count) ? '0 : n[SLOT_W-1:0];
  endfunction

endpackage

/* rtl/core/pwrr_cell.sv */
module pwrr_cell
  import pwrr_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [ID_W-1:0]   wr_id,
  input  logic [PRIO_W-1:0] wr_prio,
  input  logic [ID_W-1:0]   nb_id,
  input  logic [PRIO_W-1:0] nb_prio,
  input  logic [ID_W-1:0]   key_id,
  input  logic              in_range,
  input  logic              seen_in,
  output logic [ID_W-1:0]   id_o,
  output logic [PRIO_W-1:0] prio_o,
  output logic              seen_out,
  output logic              hit
);

  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic              match;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      id_r   <= wr_id;
      prio_r <= wr_prio;
    end else if (ctrl.shift) begin
      // compaction: take the right-hand neighbour's entry
      id_r   <= nb_id;
      prio_r <= nb_prio;
    end
  end

  assign match    = in_range && (id_r == key_id);
  assign hit      = match && !seen_in;
  assign seen_out = seen_in || match;
  assign id_o     = id_r;
  assign prio_o   = prio_r;

endmodule

/* rtl/core/priority_weighted_round_robin_core.sv */
// Round-robin thread scheduler with priority-weighted time slices.
// Input channel: a word (in_op, in_thread_id, in_priority_req, in_terminated)
// is taken at a rising edge with start high and busy low. Ops: add, remove,
// tick, and a no-op code that just reports the current state.
// Result channel: one word per input word, shown for exactly one cycle with
// out_valid high; the receiver cannot stall it and must take it then.
// A word accepted at edge N is executed during the next cycle and
// its result is shown in the cycle after that. busy is high only in the
// execute cycle, so a new word may be given while a result is shown,
// but not while one is executing. The table search and compaction run
// through the chain of 16 cells within the execute cycle.
// Config channel: cfg_data is the slice length, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high, write only while idle.
// Reset (rst_n low, synchronous): table empty, current slot and tick count
// zero, slice length 5; table contents stay undefined until written.
`include "priority_weighted_round_robin_core_macros.svh"

module priority_weighted_round_robin_core
  import pwrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [ID_W-1:0]    in_thread_id,
  input  logic [PRIO_W-1:0]  in_priority_req,
  input  logic               in_terminated,
  output logic               out_valid,
  output logic [ID_W-1:0]    out_running_thread,
  output logic               out_switched,
  output logic               out_table_empty,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SLICE_W-1:0] cfg_data
);

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [ID_W-1:0]     id_r;
  logic [PRIO_W-1:0]   prio_r;
  logic                term_r;
  logic [SLICE_W-1:0]  slice_r;

  logic [CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic [SLOT_W-1:0]   current_slot_r, current_slot_nxt;
  logic [TICK_W-1:0]   tick_count_r, tick_count_nxt;

  logic                sw_r, sw_nxt;
  status_t             status_r, status_nxt;
  logic                run_hold_r, run_hold_nxt;
  logic [ID_W-1:0]     run_r, run_nxt;

  cell_ctrl_t          ctrl [NUM_CELLS];
  logic [ID_W-1:0]     cell_id [NUM_CELLS];
  logic [PRIO_W-1:0]   cell_prio [NUM_CELLS];
  logic [NUM_CELLS:0]  seen;
  logic [NUM_CELLS-1:0] hit;
  logic [NUM_CELLS-1:0] in_range;
  logic [SLOT_W-1:0]   found_idx;

  logic                accept;
  logic                rm_en;
  logic [SLOT_W-1:0]   rm_slot;
  logic                inc_tick;
  logic [SLOT_W-1:0]   cur2;
  logic [TICK_W-1:0]   limit;

  assign accept    = start && !busy;
  assign busy      = (state_r == S_EXEC);
  assign cfg_ready = 1'b1;

  // cell chain
  assign seen[0] = 1'b0;
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    assign in_range[g] = (CNT_W'(g) < entry_count_r);
    pwrr_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[g]),
      .wr_id    (id_r),
      .wr_prio  (prio_r),
      .nb_id    (cell_id[(g < NUM_CELLS - 1) ? g + 1 : g]),
      .nb_prio  (cell_prio[(g < NUM_CELLS - 1) ? g + 1 : g]),
      .key_id   (id_r),
      .in_range (in_range[g]),
      .seen_in  (seen[g]),
      .id_o     (cell_id[g]),
      .prio_o   (cell_prio[g]),
      .seen_out (seen[g+1]),
      .hit      (hit[g])
    );
  end

  always_comb begin
    found_idx = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (hit[i]) begin
        found_idx = found_idx | SLOT_W'(i);
      end
    end
  end

  // fsm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // execute: updates scheduler state during the execute cycle
  always_comb begin
    entry_count_nxt  = entry_count_r;
    current_slot_nxt = current_slot_r;
    tick_count_nxt   = tick_count_r;
    sw_nxt           = 1'b0;
    status_nxt       = STAT_OK;
    run_hold_nxt     = 1'b0;
    run_nxt          = '0;
    rm_en            = 1'b0;
    rm_slot          = '0;
    inc_tick         = 1'b0;
    cur2             = current_slot_r;
    limit            = TICK_W'(slice_r) * TICK_W'(cell_prio[current_slot_r]);
    for (int i = 0; i < NUM_CELLS; i++) begin
      ctrl[i] = '0;
    end

    case (op_r)
      OP_ADD: begin
        if (entry_count_r == CNT_W'(NUM_CELLS)) begin
          status_nxt = STAT_FULL;
        end else begin
          for (int i = 0; i < NUM_CELLS; i++) begin
            ctrl[i].load = (CNT_W'(i) == entry_count_r);
          end
          if (entry_count_r == '0) begin
            current_slot_nxt = '0;
            tick_count_nxt   = '0;
            sw_nxt           = 1'b1;
          end
          entry_count_nxt = entry_count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!seen[NUM_CELLS]) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          rm_en   = 1'b1;
          rm_slot = found_idx;
        end
      end
      OP_TICK: begin
        run_hold_nxt = 1'b1;
        if (entry_count_r == '0) begin
          status_nxt = STAT_IDLE_TICK;
        end else begin
          // slice expiry moves on before the tick is reported
          if (tick_count_r == limit) begin
            tick_count_nxt = '0;
            if (entry_count_r > CNT_W'(1)) sw_nxt = 1'b1;
            cur2 = adv_slot(current_slot_r, entry_count_r);
          end
          current_slot_nxt = cur2;
          run_nxt          = cell_id[cur2];
          inc_tick         = 1'b1;
          if (term_r) begin
            rm_en   = 1'b1;
            rm_slot = cur2;
            sw_nxt  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (rm_en) begin
      if (rm_slot == current_slot_nxt) begin
        tick_count_nxt   = '0;
        current_slot_nxt = adv_slot(current_slot_nxt, entry_count_r);
        sw_nxt           = 1'b1;
      end
      for (int i = 0; i < NUM_CELLS; i++) begin
        ctrl[i].shift = (SLOT_W'(i) >= rm_slot);
      end
      entry_count_nxt = entry_count_r - CNT_W'(1);
      if (current_slot_nxt > rm_slot) begin
        current_slot_nxt = current_slot_nxt - SLOT_W'(1);
      end
      if (entry_count_nxt == '0) begin
        current_slot_nxt = '0;
      end
    end

    if (inc_tick) begin
      tick_count_nxt = tick_count_nxt + TICK_W'(1);
    end

    if (state_r != S_EXEC) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        ctrl[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r  <= '0;
      current_slot_r <= '0;
      tick_count_r   <= '0;
      slice_r        <= SLICE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slice_r <= cfg_data;
      end
      if (state_r == S_EXEC) begin
        entry_count_r  <= entry_count_nxt;
        current_slot_r <= current_slot_nxt;
        tick_count_r   <= tick_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_op);
      id_r   <= in_thread_id;
      prio_r <= in_priority_req;
      term_r <= in_terminated;
    end
    if (state_r == S_EXEC) begin
      sw_r       <= sw_nxt;
      status_r   <= status_nxt;
      run_hold_r <= run_hold_nxt;
      run_r      <= run_nxt;
    end
  end

  // result word, read from the updated table unless a tick captured it
  assign out_valid          = (state_r == S_RESP);
  assign out_table_empty    = (entry_count_r == '0);
  assign out_switched       = sw_r;
  assign out_status         = status_r;
  assign out_running_thread = run_hold_r ? run_r :
                              (entry_count_r == '0) ? '0 : cell_id[current_slot_r];

  `PWRR_ASSERT_IMP(a_count_bound, 1'b1, entry_count_r <= CNT_W'(NUM_CELLS),
    "entry count beyond table size")
  `PWRR_ASSERT_IMP(a_slot_in_table, entry_count_r != '0,
    CNT_W'(current_slot_r) < entry_count_r, "current slot outside table")
  `PWRR_ASSERT_IMP(a_slot_empty, entry_count_r == '0, current_slot_r == '0,
    "current slot not cleared on empty table")
  `PWRR_ASSERT_NXT(a_exec_resp, state_r == S_EXEC, out_valid,
    "execute cycle not followed by result")

endmodule

/* bench/priority_weighted_round_robin_checker.sv */
`timescale 1ns / 1ps

module priority_weighted_round_robin_checker
  import pwrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_op,
  input  logic [ID_W-1:0]    in_thread_id,
  input  logic [PRIO_W-1:0]  in_priority_req,
  input  logic               in_terminated,
  input  logic               out_valid,
  input  logic [ID_W-1:0]    out_running_thread,
  input  logic               out_switched,
  input  logic               out_table_empty,
  input  logic [1:0]         out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [SLICE_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [ID_W-1:0] running;
    logic            sw;
    logic            empty;
    status_t         status;
  } sched_result_t;

  logic [ID_W-1:0]    thread_tab [NUM_CELLS];
  logic [PRIO_W-1:0]  prio_tab [NUM_CELLS];
  int                 occupancy;
  int                 cur_slot;
  logic [TICK_W-1:0]  slice_ticks;
  logic [SLICE_W-1:0] slice_len;
  sched_result_t      due_q [$];

  function automatic void next_slot();
    cur_slot = (cur_slot + 1 >= occupancy) ? 0 : cur_slot + 1;
  endfunction

  // take out one entry and close the gap; returns 1 if it was the current one
  function automatic bit drop_entry(input int slot);
    bit was_cur;
    int i;
    was_cur = (slot == cur_slot);
    if (was_cur) begin
      slice_ticks = '0;
      next_slot();
    end
    for (i = slot; i + 1 < occupancy; i++) begin
      thread_tab[i] = thread_tab[i+1];
      prio_tab[i]   = prio_tab[i+1];
    end
    occupancy--;
    if (cur_slot > slot) cur_slot--;
    if (occupancy == 0) cur_slot = 0;
    return was_cur;
  endfunction

  function automatic sched_result_t schedule_word(input op_t op,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [PRIO_W-1:0] prio,
                                                  input logic term);
    sched_result_t r;
    int found;
    int limit;
    int i;
    r = '0;
    r.status = STAT_OK;
    case (op)
      OP_ADD: begin
        if (occupancy >= NUM_CELLS) begin
          r.status = STAT_FULL;
        end else begin
          thread_tab[occupancy] = id;
          prio_tab[occupancy]   = prio;
          if (occupancy == 0) begin
            cur_slot    = 0;
            slice_ticks = '0;
            r.sw        = 1'b1;
          end
          occupancy++;
        end
      end
      OP_REMOVE: begin
        found = occupancy;
        for (i = 0; i < occupancy && found == occupancy; i++)
          if (thread_tab[i] == id) found = i;
        if (found >= occupancy) r.status = STAT_NOT_FOUND;
        else if (drop_entry(found)) r.sw = 1'b1;
      end
      OP_TICK: begin
        if (occupancy == 0) begin
          r.status = STAT_IDLE_TICK;
        end else begin
          limit = int'(slice_len) * int'(prio_tab[cur_slot]);
          if (int'(slice_ticks) == limit) begin
            slice_ticks = '0;
            if (occupancy > 1) r.sw = 1'b1;
            next_slot();
          end
          // the thread that ran is reported even if it finishes now
          r.running = thread_tab[cur_slot];
          if (term) begin
            void'(drop_entry(cur_slot));
            r.sw = 1'b1;
          end
          slice_ticks = slice_ticks + 1'b1;
        end
      end
      default: ;
    endcase
    if (op != OP_TICK && occupancy > 0) r.running = thread_tab[cur_slot];
    r.empty = (occupancy == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      occupancy   = 0;
      cur_slot    = 0;
      slice_ticks = '0;
      slice_len   = SLICE_RESET;
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) slice_len = cfg_data;
      if (out_valid) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, running_thread %0d status %0d",
                   $time, out_running_thread, out_status);
        end else begin
          want = due_q.pop_front();
          if (out_running_thread !== want.running) begin
            errors++;
            $display("%0t: running_thread expected %0d actual %0d",
                     $time, want.running, out_running_thread);
          end
          if (out_switched !== want.sw) begin
            errors++;
            $display("%0t: switched expected %0d actual %0d", $time, want.sw, out_switched);
          end
          if (out_table_empty !== want.empty) begin
            errors++;
            $display("%0t: table_empty expected %0d actual %0d",
                     $time, want.empty, out_table_empty);
          end
          if (out_status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
        end
      end
      if (start && !busy)
        due_q.push_back(schedule_word(op_t'(in_op), in_thread_id, in_priority_req,
                                      in_terminated));
    end
    pending = due_q.size();
  end

endmodule

/* bench/priority_weighted_round_robin_core_tb.sv */
`timescale 1ns / 1ps

module priority_weighted_round_robin_core_tb;
  import pwrr_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic [ID_W-1:0]    in_thread_id;
  logic [PRIO_W-1:0]  in_priority_req;
  logic               in_terminated;
  logic               out_valid;
  logic [ID_W-1:0]    out_running_thread;
  logic               out_switched;
  logic               out_table_empty;
  logic [1:0]         out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SLICE_W-1:0] cfg_data;
  int                 fail_count;
  int                 words_due;
  int                 idle_pct;
  bit                 fill_bias;

  priority_weighted_round_robin_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_thread_id      (in_thread_id),
    .in_priority_req   (in_priority_req),
    .in_terminated     (in_terminated),
    .out_valid         (out_valid),
    .out_running_thread(out_running_thread),
    .out_switched      (out_switched),
    .out_table_empty   (out_table_empty),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  priority_weighted_round_robin_checker sched_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_thread_id      (in_thread_id),
    .in_priority_req   (in_priority_req),
    .in_terminated     (in_terminated),
    .out_valid         (out_valid),
    .out_running_thread(out_running_thread),
    .out_switched      (out_switched),
    .out_table_empty   (out_table_empty),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .errors            (fail_count),
    .pending           (words_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input op_t op, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input logic term);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_thread_id    <= id;
    in_priority_req <= prio;
    in_terminated   <= term;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // only once every word has come back, so the scheduler is idle
  task automatic write_slice(input logic [SLICE_W-1:0] len);
    start <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word();
    int r;
    op_t op;
    logic [ID_W-1:0] id;
    logic [PRIO_W-1:0] prio;
    r = $urandom_range(99);
    if (fill_bias)
      op = (r < 45) ? OP_ADD : (r < 55) ? OP_REMOVE : (r < 96) ? OP_TICK : OP_NONE;
    else
      op = (r < 15) ? OP_ADD : (r < 40) ? OP_REMOVE : (r < 96) ? OP_TICK : OP_NONE;
    // a narrow id range now and then gives duplicates
    id   = ($urandom_range(3) == 0) ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(15));
    // mostly low priorities so that slices expire often
    prio = ($urandom_range(3) == 0) ? PRIO_W'($urandom_range(15)) :
                                      PRIO_W'($urandom_range(3));
    send_word(op, id, prio, $urandom_range(9) == 0);
  endtask

  initial begin
    int k;
    int phase;
    start           = 1'b0;
    in_op           = OP_NONE;
    in_thread_id    = '0;
    in_priority_req = '0;
    in_terminated   = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    rst_n           = 1'b0;
    idle_pct        = 15;
    fill_bias       = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table
    send_word(OP_TICK, 4'd0, 4'd0, 1'b1);
    send_word(OP_REMOVE, 4'd3, 4'd0, 1'b0);
    send_word(OP_NONE, 4'd15, 4'd15, 1'b1);
    // first add, zero priority, duplicate id
    send_word(OP_ADD, 4'd15, 4'd15, 1'b0);
    send_word(OP_ADD, 4'd0, 4'd0, 1'b0);
    send_word(OP_ADD, 4'd15, 4'd1, 1'b0);
    send_word(OP_TICK, 4'd0, 4'd0, 1'b0);
    // removes the first match, which is the current thread
    send_word(OP_REMOVE, 4'd15, 4'd0, 1'b0);
    send_word(OP_TICK, 4'd0, 4'd0, 1'b0);
    send_word(OP_TICK, 4'd0, 4'd0, 1'b1);
    send_word(OP_TICK, 4'd0, 4'd0, 1'b0);
    send_word(OP_NONE, 4'd0, 4'd0, 1'b0);
    send_word(OP_REMOVE, 4'd0, 4'd0, 1'b0);

    // slice shortened mid-slice: the slice ends at the new limit,
    // and with one thread the expiry does not switch
    idle_pct = 0;
    send_word(OP_ADD, 4'd9, 4'd15, 1'b0);
    write_slice(8'd255);
    repeat (20) send_word(OP_TICK, 4'd0, 4'd0, 1'b0);
    write_slice(8'd2);
    repeat (40) send_word(OP_TICK, 4'd0, 4'd0, 1'b0);

    // fill up, then one add too many
    idle_pct = 15;
    for (k = 0; k < 16; k++)
      send_word(OP_ADD, k[3:0], ~k[3:0], k[0]);
    send_word(OP_TICK, 4'd0, 4'd0, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct = 15;
          write_slice(SLICE_W'($urandom_range(1, 3)));
        end
        1: begin
          idle_pct = 72;
          write_slice(8'd0);
        end
        default: begin
          idle_pct = 0;
          write_slice(SLICE_W'($urandom_range(1, 10)));
        end
      endcase
      for (k = 0; k < 560; k++) begin
        if (k % 80 == 0) fill_bias = !fill_bias;
        random_word();
      end
    end

    start <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
